FILE: design/ldft_pkg.sv
// ----------------------------------------------------------------------------
// ldft_pkg: shared types and constants for the LED frame transmitter
// Frame layout, register indexes, sequencer stage codes and channel payloads.
// ----------------------------------------------------------------------------
package ldft_pkg;

   localparam int FRAME_LEN = 17;
   localparam int BYTE_POS_W = 5;
   localparam int HEADER_LEN = 7;

   // fixed frame header: address, enable, five range bytes
   localparam logic [7:0] FRAME_HEADER [HEADER_LEN] = '{
      8'h90, 8'h1F, 8'h10, 8'h10, 8'h10, 8'h1A, 8'h1A
   };

   // configuration register indexes
   localparam logic [1:0] CSR_RED_SLOT   = 2'd0;
   localparam logic [1:0] CSR_GREEN_SLOT = 2'd1;
   localparam logic [1:0] CSR_BLUE_SLOT  = 2'd2;

   // slot source codes
   localparam logic [1:0] SRC_RED   = 2'd0;
   localparam logic [1:0] SRC_GREEN = 2'd1;
   localparam logic [1:0] SRC_BLUE  = 2'd2;

   // command codes
   localparam logic CMD_TICK = 1'b0;
   localparam logic CMD_SEND = 1'b1;

   // sub-phase codes inside a byte
   localparam logic [1:0] PH_DATA     = 2'd0;
   localparam logic [1:0] PH_CLK_HIGH = 2'd1;
   localparam logic [1:0] PH_CLK_LOW  = 2'd2;
   localparam logic [1:0] PH_ACK      = 2'd3;

   typedef enum logic [3:0] {
      STAGE_IDLE  = 4'b0001,
      STAGE_START = 4'b0010,
      STAGE_BYTES = 4'b0100,
      STAGE_STOP  = 4'b1000
   } stage_type;

   typedef struct packed {
      logic       command;
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
      logic [7:0] ww_level;
      logic [7:0] cw_level;
   } req_type;

   typedef struct packed {
      logic sda_level;
      logic sda_driven;
      logic scl_level;
      logic busy_res;
      logic frame_done;
      logic rejected;
   } rsp_type;

   typedef struct packed {
      logic [1:0] index;
      logic [1:0] wdata;
   } csr_type;

   typedef struct packed {
      logic [1:0] red_src;
      logic [1:0] green_src;
      logic [1:0] blue_src;
   } slot_cfg_type;

endpackage

FILE: design/ldft_if.sv
// ----------------------------------------------------------------------------
// ldft_if: valid/ready channels of the LED frame transmitter
// Request, response and register-write channels with a monitor view.
// ----------------------------------------------------------------------------
interface ldft_req_if;
   logic             valid;
   logic             ready;
   ldft_pkg::req_type payload;
   modport source  (output valid, output payload, input ready);
   modport sink    (input valid, input payload, output ready);
   modport monitor (input valid, input payload, input ready);
endinterface

interface ldft_rsp_if;
   logic             valid;
   logic             ready;
   ldft_pkg::rsp_type payload;
   modport source  (output valid, output payload, input ready);
   modport sink    (input valid, input payload, output ready);
   modport monitor (input valid, input payload, input ready);
endinterface

interface ldft_csr_if;
   logic             valid;
   logic             ready;
   ldft_pkg::csr_type payload;
   modport source  (output valid, output payload, input ready);
   modport sink    (input valid, input payload, output ready);
   modport monitor (input valid, input payload, input ready);
endinterface

FILE: design/ldft_sequencer.sv
// ----------------------------------------------------------------------------
// ldft_sequencer: frame store and bus phase state machine
// Loads the frame on send, advances one bus phase per tick, reports lines.
// ----------------------------------------------------------------------------
module ldft_sequencer (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   step,
   input  ldft_pkg::req_type      req,
   input  ldft_pkg::slot_cfg_type cfg,
   output ldft_pkg::rsp_type      result
);

   ldft_pkg::stage_type            stage_ff, stage_in;
   logic [ldft_pkg::BYTE_POS_W-1:0] byte_pos_ff, byte_pos_in;
   logic [2:0]                     bit_pos_ff, bit_pos_in;
   logic [1:0]                     sub_ff, sub_in;
   logic                           sda_ff, sda_in;
   logic                           scl_ff, scl_in;
   logic                           drive_ff, drive_in;
   logic [7:0]                     frame_ff [ldft_pkg::FRAME_LEN];
   logic [7:0]                     frame_in [ldft_pkg::FRAME_LEN];
   logic                           load;
   logic                           done;
   logic                           rej;
   logic [7:0]                     slot_level [5];
   logic [ldft_pkg::BYTE_POS_W-1:0] byte_pos_inc;

   function automatic logic [7:0] pick_color(input logic [1:0] sel,
                                             input ldft_pkg::req_type r);
      logic [7:0] level;
      unique case (sel)
         ldft_pkg::SRC_RED:   level = r.red;
         ldft_pkg::SRC_GREEN: level = r.green;
         ldft_pkg::SRC_BLUE:  level = r.blue;
         default:             level = 8'd0;
      endcase
      return level;
   endfunction

   // output slot order in the frame: blue, green, red, warm white, cold white
   assign slot_level[0] = pick_color(cfg.blue_src, req);
   assign slot_level[1] = pick_color(cfg.green_src, req);
   assign slot_level[2] = pick_color(cfg.red_src, req);
   assign slot_level[3] = req.ww_level;
   assign slot_level[4] = req.cw_level;

   // brightness * 4 split into low and high 5-bit halves
   always_comb begin
      for (int i = 0; i < ldft_pkg::HEADER_LEN; i++) begin
         frame_in[i] = ldft_pkg::FRAME_HEADER[i];
      end
      for (int s = 0; s < 5; s++) begin
         frame_in[ldft_pkg::HEADER_LEN + 2*s]     = {3'b000, slot_level[s][2:0], 2'b00};
         frame_in[ldft_pkg::HEADER_LEN + 2*s + 1] = {3'b000, slot_level[s][7:3]};
      end
   end

   assign byte_pos_inc = byte_pos_ff + 1'b1;

   always_comb begin
      stage_in    = stage_ff;
      byte_pos_in = byte_pos_ff;
      bit_pos_in  = bit_pos_ff;
      sub_in      = sub_ff;
      sda_in      = sda_ff;
      scl_in      = scl_ff;
      drive_in    = drive_ff;
      load        = 1'b0;
      done        = 1'b0;
      rej         = 1'b0;
      if (step) begin
         if (req.command == ldft_pkg::CMD_SEND) begin
            if (stage_ff != ldft_pkg::STAGE_IDLE) begin
               rej = 1'b1;
            end else begin
               load        = 1'b1;
               stage_in    = ldft_pkg::STAGE_START;
               byte_pos_in = '0;
               bit_pos_in  = 3'd7;
               sub_in      = ldft_pkg::PH_DATA;
            end
         end else begin
            unique case (stage_ff)
               ldft_pkg::STAGE_IDLE: begin
               end
               ldft_pkg::STAGE_START: begin
                  if (sub_ff == ldft_pkg::PH_DATA) begin
                     sda_in   = 1'b0;
                     drive_in = 1'b1;
                     sub_in   = ldft_pkg::PH_CLK_HIGH;
                  end else begin
                     scl_in      = 1'b0;
                     stage_in    = ldft_pkg::STAGE_BYTES;
                     byte_pos_in = '0;
                     bit_pos_in  = 3'd7;
                     sub_in      = ldft_pkg::PH_DATA;
                  end
               end
               ldft_pkg::STAGE_BYTES: begin
                  if (byte_pos_ff >= ldft_pkg::BYTE_POS_W'(ldft_pkg::FRAME_LEN)) begin
                     // past the frame: fall into the first stop phase
                     stage_in    = ldft_pkg::STAGE_STOP;
                     byte_pos_in = '0;
                     drive_in    = 1'b1;
                     scl_in      = 1'b1;
                     sub_in      = ldft_pkg::PH_CLK_HIGH;
                  end else begin
                     unique case (sub_ff)
                        ldft_pkg::PH_DATA: begin
                           sda_in   = frame_ff[byte_pos_ff][bit_pos_ff];
                           drive_in = 1'b1;
                           sub_in   = ldft_pkg::PH_CLK_HIGH;
                        end
                        ldft_pkg::PH_CLK_HIGH: begin
                           scl_in = 1'b1;
                           sub_in = ldft_pkg::PH_CLK_LOW;
                        end
                        ldft_pkg::PH_CLK_LOW: begin
                           scl_in = 1'b0;
                           if (bit_pos_ff == 3'd0) begin
                              sub_in = ldft_pkg::PH_ACK;
                           end else begin
                              bit_pos_in = bit_pos_ff - 1'b1;
                              sub_in     = ldft_pkg::PH_DATA;
                           end
                        end
                        default: begin
                           if (drive_ff) begin
                              drive_in = 1'b0;
                              scl_in   = 1'b1;
                           end else begin
                              scl_in      = 1'b0;
                              bit_pos_in  = 3'd7;
                              sub_in      = ldft_pkg::PH_DATA;
                              byte_pos_in = byte_pos_inc;
                              if (byte_pos_inc >= ldft_pkg::BYTE_POS_W'(ldft_pkg::FRAME_LEN))
                              begin
                                 stage_in    = ldft_pkg::STAGE_STOP;
                                 byte_pos_in = '0;
                              end
                           end
                        end
                     endcase
                  end
               end
               ldft_pkg::STAGE_STOP: begin
                  if (sub_ff == ldft_pkg::PH_DATA) begin
                     drive_in = 1'b1;
                     scl_in   = 1'b1;
                     sub_in   = ldft_pkg::PH_CLK_HIGH;
                  end else begin
                     drive_in    = 1'b1;
                     sda_in      = 1'b1;
                     done        = 1'b1;
                     stage_in    = ldft_pkg::STAGE_IDLE;
                     sub_in      = ldft_pkg::PH_DATA;
                     bit_pos_in  = 3'd7;
                     byte_pos_in = '0;
                  end
               end
               default: begin
                  stage_in = ldft_pkg::STAGE_IDLE;
               end
            endcase
         end
      end
   end

   always_comb begin
      result.sda_level  = sda_in;
      result.sda_driven = drive_in;
      result.scl_level  = scl_in;
      result.busy_res   = (stage_in != ldft_pkg::STAGE_IDLE);
      result.frame_done = done;
      result.rejected   = rej;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_ff    <= ldft_pkg::STAGE_IDLE;
         byte_pos_ff <= '0;
         bit_pos_ff  <= 3'd7;
         sub_ff      <= ldft_pkg::PH_DATA;
         sda_ff      <= 1'b1;
         scl_ff      <= 1'b1;
         drive_ff    <= 1'b1;
      end else begin
         stage_ff    <= stage_in;
         byte_pos_ff <= byte_pos_in;
         bit_pos_ff  <= bit_pos_in;
         sub_ff      <= sub_in;
         sda_ff      <= sda_in;
         scl_ff      <= scl_in;
         drive_ff    <= drive_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         frame_ff <= frame_in;
      end
   end

endmodule

FILE: design/led_driver_frame_transmitter.sv
// ----------------------------------------------------------------------------
// led_driver_frame_transmitter: two-wire frame sender for a 5-channel LED driver
// Each result is registered in the response register, or in the skid entry
// while the output is held. One item per cycle while the skid is free; the
//   register + skid buffer keeps requests open while a result waits to be taken.
// Reset: synchronous, active high; bus lines idle high, sequencer idle, slot
//   sources back to red/green/blue, response buffer empty. No clearing pass.
// ----------------------------------------------------------------------------
module led_driver_frame_transmitter (
   input  logic               clock,
   input  logic               reset,
   ldft_req_if.sink           req_bus,
   ldft_rsp_if.source         rsp_bus,
   ldft_csr_if.sink           csr_bus
);

   // slot source registers
   logic [1:0]             red_src_ff, green_src_ff, blue_src_ff;
   ldft_pkg::slot_cfg_type slot_cfg;

   // response buffer: output register plus skid entry
   logic                   rsp_valid_ff, rsp_valid_in;
   ldft_pkg::rsp_type      rsp_data_ff, rsp_data_in;
   logic                   skid_valid_ff, skid_valid_in;
   ldft_pkg::rsp_type      skid_data_ff, skid_data_in;

   logic                   req_take;
   logic                   rsp_take;
   ldft_pkg::rsp_type      step_result;

   // ------------------------------------------------------------------
   // Register writes: always ready; writes outside the list are dropped.
   // ------------------------------------------------------------------
   assign csr_bus.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         red_src_ff   <= ldft_pkg::SRC_RED;
         green_src_ff <= ldft_pkg::SRC_GREEN;
         blue_src_ff  <= ldft_pkg::SRC_BLUE;
      end else if (csr_bus.valid) begin
         unique case (csr_bus.payload.index)
            ldft_pkg::CSR_RED_SLOT:   red_src_ff   <= csr_bus.payload.wdata;
            ldft_pkg::CSR_GREEN_SLOT: green_src_ff <= csr_bus.payload.wdata;
            ldft_pkg::CSR_BLUE_SLOT:  blue_src_ff  <= csr_bus.payload.wdata;
            default: begin
            end
         endcase
      end
   end

   assign slot_cfg.red_src   = red_src_ff;
   assign slot_cfg.green_src = green_src_ff;
   assign slot_cfg.blue_src  = blue_src_ff;

   // ------------------------------------------------------------------
   // Handshakes: accept while the skid entry is free (registered ready).
   // ------------------------------------------------------------------
   assign req_bus.ready = !skid_valid_ff;
   assign req_take      = req_bus.valid && !skid_valid_ff;
   assign rsp_take      = rsp_valid_ff && rsp_bus.ready;

   // Every accepted item advances the sequencer and yields one result.
   ldft_sequencer u_sequencer (
      .clock  (clock),
      .reset  (reset),
      .step   (req_take),
      .req    (req_bus.payload),
      .cfg    (slot_cfg),
      .result (step_result)
   );

   // ------------------------------------------------------------------
   // Response buffer: new results go to the output register when it is
   // free or draining, otherwise park in the skid entry.
   // ------------------------------------------------------------------
   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      rsp_data_in   = rsp_data_ff;
      skid_valid_in = skid_valid_ff;
      skid_data_in  = skid_data_ff;
      if (skid_valid_ff) begin
         // no new item can arrive; move skid forward once the output drains
         if (rsp_take) begin
            rsp_data_in   = skid_data_ff;
            skid_valid_in = 1'b0;
         end
      end else if (req_take) begin
         if (!rsp_valid_ff || rsp_take) begin
            rsp_valid_in = 1'b1;
            rsp_data_in  = step_result;
         end else begin
            skid_valid_in = 1'b1;
            skid_data_in  = step_result;
         end
      end else if (rsp_take) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff  <= rsp_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   // payload holds need no reset
   always_ff @(posedge clock) begin
      rsp_data_ff  <= rsp_data_in;
      skid_data_ff <= skid_data_in;
   end

   assign rsp_bus.valid   = rsp_valid_ff;
   assign rsp_bus.payload = rsp_data_ff;

endmodule

FILE: design/ldft_checker.sv
// ----------------------------------------------------------------------------
// ldft_checker: port-level checks for the LED frame transmitter
// Watches the response channel and flags inconsistent result items.
// ----------------------------------------------------------------------------
module ldft_checker (
   input logic              clock,
   input logic              reset,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input ldft_pkg::rsp_type rsp_payload
);

   // a stalled result holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_payload))
      else $error("stalled result changed or dropped");

   // the tick that ends the stop condition leaves the block idle with both lines high
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.frame_done |->
         !rsp_payload.busy_res && rsp_payload.sda_level &&
         rsp_payload.sda_driven && rsp_payload.scl_level)
      else $error("frame end with bus not released to idle");

   // a rejected send only happens while a frame is in flight
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.rejected |->
         rsp_payload.busy_res && !rsp_payload.frame_done)
      else $error("reject reported while idle");

   // released data only occurs during a busy ack phase
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_payload.sda_driven |-> rsp_payload.busy_res)
      else $error("data released outside a frame");

   // no result is offered right after reset
   assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result offered after reset");

endmodule

bind led_driver_frame_transmitter ldft_checker u_ldft_checker (
   .clock       (clock),
   .reset       (reset),
   .rsp_valid   (rsp_bus.valid),
   .rsp_ready   (rsp_bus.ready),
   .rsp_payload (rsp_bus.payload)
);

FILE: test/ldft_frame_checker.sv
// ----------------------------------------------------------------------------
// ldft_frame_checker: bus-phase predictor and response checker
// Watches the request, response and register channels of the LED frame
// transmitter, predicts each response and compares it field by field.
// ----------------------------------------------------------------------------
module ldft_frame_checker (
   input  logic         clock,
   input  logic         reset,
   ldft_req_if.monitor  req_mon,
   ldft_rsp_if.monitor  rsp_mon,
   ldft_csr_if.monitor  csr_mon,
   output int           mismatch_count,
   output int           pending_count
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int REPORT_LIMIT = 10;
   localparam int WORD_BASE    = 7;
   localparam int WORD_COUNT   = 5;

   // address, enable, then the five range bytes
   localparam logic [7:0] HEADER_BYTES [7] = '{
      8'h90, 8'h1F, 8'h10, 8'h10, 8'h10, 8'h1A, 8'h1A
   };

   ldft_pkg::slot_cfg_type slot_sources;
   ldft_pkg::stage_type    bus_stage;
   logic [4:0]             byte_pos;
   logic [2:0]             bit_pos;
   logic [1:0]             bus_phase;
   logic                   sda_latch;
   logic                   sda_enable;
   logic                   scl_latch;
   logic [7:0]             frame_image [ldft_pkg::FRAME_LEN];

   ldft_pkg::rsp_type expected_bus_states [$];

   initial mismatch_count = 0;

   function automatic logic [7:0] slot_level(logic [1:0] source, ldft_pkg::req_type item);
      case (source)
         ldft_pkg::SRC_RED:   return item.red;
         ldft_pkg::SRC_GREEN: return item.green;
         ldft_pkg::SRC_BLUE:  return item.blue;
         default:             return 8'd0;
      endcase
   endfunction

   // Advance the bus model by one item and return the line state it leaves.
   function automatic ldft_pkg::rsp_type advance_bus(ldft_pkg::req_type item);
      ldft_pkg::rsp_type state;
      logic [7:0]        levels [WORD_COUNT];
      logic [9:0]        word;
      state = '0;
      if (item.command == ldft_pkg::CMD_SEND) begin
         if (bus_stage != ldft_pkg::STAGE_IDLE) begin
            state.rejected = 1'b1;
         end else begin
            for (int i = 0; i < 7; i++) frame_image[i] = HEADER_BYTES[i];
            // words go out in slot order blue, green, red, warm, cold
            levels[0] = slot_level(slot_sources.blue_src, item);
            levels[1] = slot_level(slot_sources.green_src, item);
            levels[2] = slot_level(slot_sources.red_src, item);
            levels[3] = item.ww_level;
            levels[4] = item.cw_level;
            for (int i = 0; i < WORD_COUNT; i++) begin
               word = {levels[i], 2'b00};
               frame_image[WORD_BASE + 2*i]     = {3'b000, word[4:0]};
               frame_image[WORD_BASE + 2*i + 1] = {3'b000, word[9:5]};
            end
            bus_stage = ldft_pkg::STAGE_START;
            byte_pos  = '0;
            bit_pos   = 3'd7;
            bus_phase = ldft_pkg::PH_DATA;
         end
      end else begin
         case (bus_stage)
            ldft_pkg::STAGE_START: begin
               if (bus_phase == ldft_pkg::PH_DATA) begin
                  sda_latch  = 1'b0;
                  sda_enable = 1'b1;
                  bus_phase  = ldft_pkg::PH_CLK_HIGH;
               end else begin
                  scl_latch = 1'b0;
                  bus_stage = ldft_pkg::STAGE_BYTES;
                  byte_pos  = '0;
                  bit_pos   = 3'd7;
                  bus_phase = ldft_pkg::PH_DATA;
               end
            end
            ldft_pkg::STAGE_BYTES: begin
               if (byte_pos >= ldft_pkg::FRAME_LEN) begin
                  bus_stage = ldft_pkg::STAGE_STOP;
                  byte_pos  = '0;
                  bus_phase = ldft_pkg::PH_DATA;
               end
               if (bus_stage == ldft_pkg::STAGE_STOP) begin
                  sda_enable = 1'b1;
                  scl_latch  = 1'b1;
                  bus_phase  = ldft_pkg::PH_CLK_HIGH;
               end else begin
                  case (bus_phase)
                     ldft_pkg::PH_DATA: begin
                        sda_latch  = frame_image[byte_pos][bit_pos];
                        sda_enable = 1'b1;
                        bus_phase  = ldft_pkg::PH_CLK_HIGH;
                     end
                     ldft_pkg::PH_CLK_HIGH: begin
                        scl_latch = 1'b1;
                        bus_phase = ldft_pkg::PH_CLK_LOW;
                     end
                     ldft_pkg::PH_CLK_LOW: begin
                        scl_latch = 1'b0;
                        if (bit_pos == 3'd0) bus_phase = ldft_pkg::PH_ACK;
                        else begin
                           bit_pos   = bit_pos - 3'd1;
                           bus_phase = ldft_pkg::PH_DATA;
                        end
                     end
                     default: begin
                        // ack slot: release data with clock high, then drop clock
                        if (sda_enable) begin
                           sda_enable = 1'b0;
                           scl_latch  = 1'b1;
                        end else begin
                           scl_latch = 1'b0;
                           bit_pos   = 3'd7;
                           bus_phase = ldft_pkg::PH_DATA;
                           byte_pos  = byte_pos + 5'd1;
                           if (byte_pos >= ldft_pkg::FRAME_LEN) begin
                              bus_stage = ldft_pkg::STAGE_STOP;
                              byte_pos  = '0;
                           end
                        end
                     end
                  endcase
               end
            end
            ldft_pkg::STAGE_STOP: begin
               if (bus_phase == ldft_pkg::PH_DATA) begin
                  sda_enable = 1'b1;
                  scl_latch  = 1'b1;
                  bus_phase  = ldft_pkg::PH_CLK_HIGH;
               end else begin
                  sda_enable       = 1'b1;
                  sda_latch        = 1'b1;
                  state.frame_done = 1'b1;
                  bus_stage        = ldft_pkg::STAGE_IDLE;
                  bus_phase        = ldft_pkg::PH_DATA;
                  bit_pos          = 3'd7;
                  byte_pos         = '0;
               end
            end
            default: ;
         endcase
      end
      state.sda_level  = sda_latch;
      state.sda_driven = sda_enable;
      state.scl_level  = scl_latch;
      state.busy_res   = (bus_stage != ldft_pkg::STAGE_IDLE);
      return state;
   endfunction

   task automatic check_field(string field, logic want, logic got);
      if (got !== want) begin
         mismatch_count++;
         if (mismatch_count <= REPORT_LIMIT)
            $display("%0t: %s mismatch, expected %b got %b", $realtime, field, want, got);
      end
   endtask

   always @(posedge clock) begin : watch
      ldft_pkg::rsp_type want;
      ldft_pkg::rsp_type got;
      if (reset) begin
         slot_sources.red_src   = ldft_pkg::SRC_RED;
         slot_sources.green_src = ldft_pkg::SRC_GREEN;
         slot_sources.blue_src  = ldft_pkg::SRC_BLUE;
         bus_stage  = ldft_pkg::STAGE_IDLE;
         byte_pos   = '0;
         bit_pos    = 3'd7;
         bus_phase  = ldft_pkg::PH_DATA;
         sda_latch  = 1'b1;
         scl_latch  = 1'b1;
         sda_enable = 1'b1;
         expected_bus_states.delete();
      end else begin
         if (csr_mon.valid && csr_mon.ready) begin
            case (csr_mon.payload.index)
               ldft_pkg::CSR_RED_SLOT:   slot_sources.red_src   = csr_mon.payload.wdata;
               ldft_pkg::CSR_GREEN_SLOT: slot_sources.green_src = csr_mon.payload.wdata;
               ldft_pkg::CSR_BLUE_SLOT:  slot_sources.blue_src  = csr_mon.payload.wdata;
               default: ;
            endcase
         end
         // retire before predicting: a response never belongs to this edge's item
         if (rsp_mon.valid && rsp_mon.ready) begin
            got = rsp_mon.payload;
            if (expected_bus_states.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= REPORT_LIMIT)
                  $display("%0t: response %b with nothing expected", $realtime, got);
            end else begin
               want = expected_bus_states.pop_front();
               check_field("sda_level", want.sda_level, got.sda_level);
               check_field("sda_driven", want.sda_driven, got.sda_driven);
               check_field("scl_level", want.scl_level, got.scl_level);
               check_field("busy_res", want.busy_res, got.busy_res);
               check_field("frame_done", want.frame_done, got.frame_done);
               check_field("rejected", want.rejected, got.rejected);
            end
         end
         if (req_mon.valid && req_mon.ready)
            expected_bus_states.push_back(advance_bus(req_mon.payload));
      end
      pending_count = expected_bus_states.size();
   end

endmodule

FILE: test/led_driver_frame_transmitter_tb.sv
// ----------------------------------------------------------------------------
// led_driver_frame_transmitter_tb: frame transmitter stimulus and verdict
// Sends whole frames under several slot-source settings, with rejected sends
// and random payload noise mixed into the tick stream, random gaps on the
// request side and random stalls on the response side. A separate checker
// predicts every bus phase; this module only drives and reports.
// ----------------------------------------------------------------------------
module led_driver_frame_transmitter_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam time CLK_PERIOD   = 12ns;
   localparam int  RESET_CYCLES = 6;
   // start, 17 bytes of 8 bits at 3 phases plus a 2-phase ack, stop
   localparam int  FRAME_TICKS  = 2 + ldft_pkg::FRAME_LEN * (8 * 3 + 2) + 2;
   localparam int  STALL_LIMIT  = 2000;
   localparam int  DRAIN_CYCLES = 4;
   localparam int  NOISE_PCT    = 3;
   localparam int  GAP_PCT      = 20;
   localparam int  STALL_PCT    = 15;
   // slot source with no color behind it, and a register index nothing decodes
   localparam logic [1:0] SRC_NONE   = 2'd3;
   localparam logic [1:0] CSR_UNUSED = 2'd3;

   logic clock;
   logic reset;
   int   mismatch_count;
   int   pending_count;
   int   idle_cycles;
   int   stall_left;
   logic calm;   // suppress new gaps and stalls on both sides while set

   ldft_req_if req_ch ();
   ldft_rsp_if rsp_ch ();
   ldft_csr_if csr_ch ();

   led_driver_frame_transmitter dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_ch),
      .rsp_bus (rsp_ch),
      .csr_bus (csr_ch)
   );

   ldft_frame_checker frame_checker (
      .clock          (clock),
      .reset          (reset),
      .req_mon        (req_ch),
      .rsp_mon        (rsp_ch),
      .csr_mon        (csr_ch),
      .mismatch_count (mismatch_count),
      .pending_count  (pending_count)
   );

   initial begin
      clock = 1'b0;
      forever #(CLK_PERIOD / 2) clock = ~clock;
   end

   // Mostly short gaps, now and then a long one.
   function automatic int pick_gap();
      if ($urandom_range(0, 99) < 85) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   function automatic ldft_pkg::req_type random_item(logic command);
      ldft_pkg::req_type item;
      item.command  = command;
      item.red      = $urandom_range(0, 255);
      item.green    = $urandom_range(0, 255);
      item.blue     = $urandom_range(0, 255);
      item.ww_level = $urandom_range(0, 255);
      item.cw_level = $urandom_range(0, 255);
      return item;
   endfunction

   function automatic ldft_pkg::req_type uniform_send(logic [7:0] level);
      return '{command: ldft_pkg::CMD_SEND, red: level, green: level, blue: level,
               ww_level: level, cw_level: level};
   endfunction

   // Response side: hold ready low for random stretches unless calm.
   always @(posedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
         stall_left   <= 0;
      end else if (stall_left > 0) begin
         rsp_ch.ready <= 1'b0;
         stall_left   <= stall_left - 1;
      end else if (!calm && $urandom_range(0, 99) < STALL_PCT) begin
         rsp_ch.ready <= 1'b0;
         stall_left   <= pick_gap() - 1;
      end else begin
         rsp_ch.ready <= 1'b1;
      end
   end

   // Watchdog: end the run when no channel has moved an item for too long.
   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)
          || (csr_ch.valid && csr_ch.ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // Present one item, hold it until taken, then maybe drop valid for a gap.
   task automatic send_item(ldft_pkg::req_type item);
      int gap;
      req_ch.valid   <= 1'b1;
      req_ch.payload <= item;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      if (!calm && $urandom_range(0, 99) < GAP_PCT) begin
         gap = pick_gap();
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // Drop valid and wait until every predicted response has come back.
   task automatic drain_responses();
      req_ch.valid <= 1'b0;
      do @(posedge clock); while (pending_count != 0);
   endtask

   task automatic write_csr(logic [1:0] index, logic [1:0] value);
      csr_ch.valid   <= 1'b1;
      csr_ch.payload <= '{index: index, wdata: value};
      @(posedge clock);
      while (!csr_ch.ready) @(posedge clock);
      csr_ch.valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic set_slot_sources(logic [1:0] red_src, logic [1:0] green_src,
                                   logic [1:0] blue_src);
      drain_responses();
      write_csr(ldft_pkg::CSR_RED_SLOT, red_src);
      write_csr(ldft_pkg::CSR_GREEN_SLOT, green_src);
      write_csr(ldft_pkg::CSR_BLUE_SLOT, blue_src);
   endtask

   // Start a frame, then tick it through to the stop condition with random
   // payload on the ticks and a few sends that must be rejected.
   task automatic run_frame(ldft_pkg::req_type start_item, logic drain_midway,
                            logic calm_midway);
      int ticks;
      send_item(start_item);
      // send right on the heels of the accepted one: must be rejected
      send_item(~start_item | {ldft_pkg::CMD_SEND, 40'd0});
      ticks = 0;
      while (ticks < FRAME_TICKS) begin
         if (drain_midway && ticks == FRAME_TICKS / 2) drain_responses();
         calm = calm_midway && ticks >= 100 && ticks < 250;
         if ($urandom_range(0, 99) < NOISE_PCT) begin
            send_item(random_item(ldft_pkg::CMD_SEND));
         end else begin
            send_item(random_item(ldft_pkg::CMD_TICK));
            ticks++;
         end
      end
      calm = 1'b0;
      // ticks on an idle bus change nothing
      repeat (3) send_item(random_item(ldft_pkg::CMD_TICK));
   endtask

   initial begin
      calm           = 1'b0;
      reset          <= 1'b1;
      req_ch.valid   <= 1'b0;
      req_ch.payload <= '0;
      csr_ch.valid   <= 1'b0;
      csr_ch.payload <= '0;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // ticks before any frame: all-zero and all-one payloads
      send_item('0);
      send_item({ldft_pkg::CMD_TICK, 40'hFF_FFFF_FFFF});

      // reset slot routing, full brightness everywhere
      run_frame(uniform_send(8'hFF), 1'b0, 1'b0);

      // swapped routing with an empty blue slot, all channels dark
      set_slot_sources(ldft_pkg::SRC_BLUE, ldft_pkg::SRC_RED, SRC_NONE);
      write_csr(CSR_UNUSED, 2'd1);
      run_frame(uniform_send(8'h00), 1'b1, 1'b0);

      // rotated routing, random brightness, a stretch with no idling
      set_slot_sources(ldft_pkg::SRC_GREEN, ldft_pkg::SRC_BLUE, ldft_pkg::SRC_RED);
      run_frame(random_item(ldft_pkg::CMD_SEND), 1'b0, 1'b1);

      drain_responses();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && pending_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
